// ===== sv/sobel_edge_threshold_macros.svh =====
// ---------------------------------------------------------------------------
// Sobel edge threshold assertion macros
// Clocked assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_THRESHOLD_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_MACROS_SVH

// checked only outside reset
`define SET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked in and out of reset
`define SET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sobel_et_pkg.sv =====
// ---------------------------------------------------------------------------
// Sobel edge threshold package
// Payload types, register indexes and gray conversion shared by the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sobel_et_pkg;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 11;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [CFG_DW-1:0] IMAGE_WIDTH_RST    = 11'd1024;
  localparam logic [CFG_DW-1:0] IMAGE_HEIGHT_RST   = 11'd1024;
  localparam logic [7:0]        EDGE_THRESHOLD_RST = 8'd10;

  localparam int MIN_SIZE = 3;

  // Q16 luma weights, sum is 65536
  localparam int GRAY_ACC_W = 24;
  localparam int FRAC_BITS  = 16;
  localparam logic [GRAY_ACC_W-1:0] W_RED   = 24'd19595;
  localparam logic [GRAY_ACC_W-1:0] W_GREEN = 24'd38470;
  localparam logic [GRAY_ACC_W-1:0] W_BLUE  = 24'd7471;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic       edge_res;
    logic [9:0] out_column;
    logic [9:0] out_row;
    logic       last_of_frame;
  } res_t;

  typedef struct packed {
    logic [7:0] older;
    logic [7:0] newer;
  } gray_pair_t;

  function automatic logic [7:0] to_gray(pix_t p);
    logic [GRAY_ACC_W-1:0] s;
    s = W_RED   * {16'd0, p.red}
      + W_GREEN * {16'd0, p.green}
      + W_BLUE  * {16'd0, p.blue};
    return s[GRAY_ACC_W-1:FRAC_BITS];
  endfunction

endpackage

// ===== sv/sobel_et_linebuf.sv =====
// ---------------------------------------------------------------------------
// Sobel edge threshold line buffer
// Two gray lines stored side by side, one write and one registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_et_linebuf
  import sobel_et_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output gray_pair_t      rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  gray_pair_t      wr_data
);

  gray_pair_t mem [DEPTH];
  gray_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/sobel_edge_threshold.sv =====
// ---------------------------------------------------------------------------
// Sobel edge threshold
// RGB to gray, 3x3 Sobel window over two buffered lines, squared-magnitude test.
// ---------------------------------------------------------------------------
// Takes RGB pixels in raster order and returns one request per interior
// pixel (row and column of at least 1 and below the last), carrying the
// edge flag, the pixel's coordinates and a last-of-frame mark; border
// pixels give nothing. The steps are gray conversion (the line buffer read
// runs alongside it), the Sobel sums, squaring, and the threshold compare
// into the output register. The rate, set by the single line buffer memory
// (MAX_WIDTH entries of two gray values) that is read once and written once
// per pixel, is one pixel per clock unless out_stall backs up the pipe. The
// line buffer has no reset pass; entries are always written before the next
// row reads them. The user must write image size and threshold through
// cfg_* only while no pixel is in flight; the block does not enforce this.
// Sizes are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
`timescale 1ns / 1ps

module sobel_edge_threshold
  import sobel_et_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pix_t              in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output res_t              out_data,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int SW = (CW > CFG_DW) ? CW : CFG_DW;
  localparam int SH = (RW > CFG_DW) ? RW : CFG_DW;

  // config
  logic [CFG_DW-1:0] width_cfg_r, height_cfg_r;
  logic [7:0]        thresh_r;
  logic [21:0]       lim_r;
  logic [15:0]       thresh_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= IMAGE_WIDTH_RST;
      height_cfg_r <= IMAGE_HEIGHT_RST;
      thresh_r     <= EDGE_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    width_cfg_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT:   height_cfg_r <= cfg_wdata;
        REG_EDGE_THRESHOLD: thresh_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign thresh_sq = thresh_r * thresh_r;

  always_ff @(posedge clk) begin
    lim_r <= {thresh_sq, 6'd0};
  end

  logic [SW-1:0] wcfg_ext;
  logic [SH-1:0] hcfg_ext;
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;

  always_comb begin
    wcfg_ext = SW'(width_cfg_r);
    hcfg_ext = SH'(height_cfg_r);
    if (wcfg_ext < SW'(MIN_SIZE)) begin
      eff_w = CW'(MIN_SIZE);
    end else if (wcfg_ext > SW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = wcfg_ext[CW-1:0];
    end
    if (hcfg_ext < SH'(MIN_SIZE)) begin
      eff_h = RW'(MIN_SIZE);
    end else if (hcfg_ext > SH'(MAX_HEIGHT)) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = hcfg_ext[RW-1:0];
    end
  end

  // pipeline enables
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic en_out, en4, en3, en2, en1, accept;

  assign en_out   = !out_v_r || !out_stall;
  assign en4      = !s4_v_r || en_out;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  // position counters
  logic [CW-1:0] col_r, col_pre, col_inc;
  logic [RW-1:0] row_r, row_wrap, row_pre, row_inc;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;

  always_comb begin
    if (col_r >= eff_w) begin
      col_pre  = '0;
      row_wrap = row_r + RW'(1);
    end else begin
      col_pre  = col_r;
      row_wrap = row_r;
    end
    row_pre = (row_wrap >= eff_h) ? '0 : row_wrap;
    col_inc = col_pre + CW'(1);
    row_inc = row_pre + RW'(1);
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= eff_h) ? '0 : row_inc;
    end else begin
      col_nxt = col_inc;
      row_nxt = row_pre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  logic [31:0] ocol_full, orow_full;
  logic        interior, last_pix;

  assign ocol_full = 32'(col_pre) - 32'd1;
  assign orow_full = 32'(row_pre) - 32'd1;
  assign interior  = (col_pre >= CW'(2)) && (row_pre >= RW'(2));
  assign last_pix  = (col_pre == eff_w - CW'(1)) && (row_pre == eff_h - RW'(1));

  // stage 1: pixel register, line buffer read in flight
  pix_t          s1_pix_r;
  logic [AW-1:0] s1_col_r;
  logic          s1_int_r, s1_last_r;
  logic [9:0]    s1_ocol_r, s1_orow_r;
  gray_pair_t    lb_rd, lb_wr;
  logic          lb_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_data;
      s1_col_r  <= col_pre[AW-1:0];
      s1_int_r  <= interior;
      s1_last_r <= last_pix;
      s1_ocol_r <= ocol_full[9:0];
      s1_orow_r <= orow_full[9:0];
    end
  end

  // stage 2: gray value with top and middle rows
  logic [7:0]    s2_gray_r, s2_top_r, s2_mid_r;
  logic [AW-1:0] s2_col_r;
  logic          s2_int_r, s2_last_r;
  logic [9:0]    s2_ocol_r, s2_orow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_gray_r <= to_gray(s1_pix_r);
      s2_top_r  <= lb_rd.older;
      s2_mid_r  <= lb_rd.newer;
      s2_col_r  <= s1_col_r;
      s2_int_r  <= s1_int_r;
      s2_last_r <= s1_last_r;
      s2_ocol_r <= s1_ocol_r;
      s2_orow_r <= s1_orow_r;
    end
  end

  assign lb_we       = s2_v_r && en3;
  assign lb_wr.older = s2_mid_r;
  assign lb_wr.newer = s2_gray_r;

  sobel_et_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_pre[AW-1:0]),
    .rd_data (lb_rd),
    .wr_en   (lb_we),
    .wr_addr (s2_col_r),
    .wr_data (lb_wr)
  );

  // window: 0..2 column x-2 top..bottom, 3..5 column x-1
  logic [7:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (lb_we) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= s2_top_r;
      win_r[4] <= s2_mid_r;
      win_r[5] <= s2_gray_r;
    end
  end

  logic [9:0]         sx_l, sx_r, sy_t, sy_b;
  logic signed [10:0] gx, gy;

  always_comb begin
    sx_l = 10'(win_r[0]) + {1'b0, win_r[1], 1'b0} + 10'(win_r[2]);
    sx_r = 10'(s2_top_r) + {1'b0, s2_mid_r, 1'b0} + 10'(s2_gray_r);
    sy_t = 10'(win_r[0]) + {1'b0, win_r[3], 1'b0} + 10'(s2_top_r);
    sy_b = 10'(win_r[2]) + {1'b0, win_r[5], 1'b0} + 10'(s2_gray_r);
    gx   = signed'({1'b0, sx_l} - {1'b0, sx_r});
    gy   = signed'({1'b0, sy_t} - {1'b0, sy_b});
  end

  // stage 3: gradients, interior pixels only
  logic signed [10:0] s3_gx_r, s3_gy_r;
  logic               s3_last_r;
  logic [9:0]         s3_ocol_r, s3_orow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r && s2_int_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_gx_r   <= gx;
      s3_gy_r   <= gy;
      s3_last_r <= s2_last_r;
      s3_ocol_r <= s2_ocol_r;
      s3_orow_r <= s2_orow_r;
    end
  end

  // stage 4: squares
  logic signed [21:0] px, py;
  logic [19:0]        s4_sqx_r, s4_sqy_r;
  logic               s4_last_r;
  logic [9:0]         s4_ocol_r, s4_orow_r;

  assign px = s3_gx_r * s3_gx_r;
  assign py = s3_gy_r * s3_gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_sqx_r  <= px[19:0];
      s4_sqy_r  <= py[19:0];
      s4_last_r <= s3_last_r;
      s4_ocol_r <= s3_ocol_r;
      s4_orow_r <= s3_orow_r;
    end
  end

  // output register
  logic [21:0] mag2;
  res_t        out_data_r, out_data_nxt;

  assign mag2 = 22'(s4_sqx_r) + 22'(s4_sqy_r);

  always_comb begin
    out_data_nxt.edge_res      = (mag2 > lim_r);
    out_data_nxt.out_column    = s4_ocol_r;
    out_data_nxt.out_row       = s4_orow_r;
    out_data_nxt.last_of_frame = s4_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/sobel_et_checker.sv =====
// ---------------------------------------------------------------------------
// Sobel edge threshold port checker
// Watches the top-level ports for reset, hold and back-pressure behavior.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sobel_edge_threshold_macros.svh"

module sobel_et_checker
  import sobel_et_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input res_t out_data
);

  // no request leaves right after reset
  `SET_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "request valid after reset")

  // a stalled request holds
  `SET_ASSERT(a_out_hold, out_valid && out_stall |=> $stable(out_data), "stalled data changed")

  // input only backs up when the output is blocked
  `SET_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "stall without cause")

  // a stalled output cannot move on to another request without a take
  `SET_ASSERT(a_no_drop, out_valid && out_stall |=> out_valid, "stalled request dropped")

endmodule

bind sobel_edge_threshold sobel_et_checker u_sobel_et_checker (.*);

// ===== verif/sobel_edge_threshold_test.sv =====
// ---------------------------------------------------------------------------
// Sobel edge threshold testbench
// Streams RGB pixels through the edge detector and checks every interior
// pixel request against an in-bench model of the gray conversion, line
// buffers and squared-magnitude threshold test. A short directed table comes
// first, then random frames under several idling patterns, size changes
// between and inside frames, and one long receiver hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_edge_threshold_test;
  import sobel_et_pkg::*;

  localparam int LINE_MAX    = 1024;
  localparam int ROWS_MAX    = 1024;
  localparam int PIPE_DRAIN  = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int END_WAIT    = 20000;
  localparam int RAND_PHASES = 16;
  localparam int MAX_REPORTS = 10;
  localparam int LUMA_R      = 19595;
  localparam int LUMA_G      = 38470;
  localparam int LUMA_B      = 7471;

  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_GIVEN} exp_kind_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    exp_kind_e kind;
    pix_t      pix;
    res_t      res;
  } dir_row_t;

  // 3x3 frames: flat white, white top row over black, then channel extremes
  localparam dir_row_t DIRECTED_ROWS [27] = '{
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_GIVEN,   24'hFFFFFF, {1'b0, 10'd1, 10'd1, 1'b1}},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'hFFFFFF, '0},
    '{EXP_NONE,    24'h000000, '0},
    '{EXP_NONE,    24'h000000, '0},
    '{EXP_NONE,    24'h000000, '0},
    '{EXP_NONE,    24'h000000, '0},
    '{EXP_NONE,    24'h000000, '0},
    '{EXP_GIVEN,   24'h000000, {1'b1, 10'd1, 10'd1, 1'b1}},
    '{EXP_PREDICT, 24'hFF0000, '0},
    '{EXP_PREDICT, 24'h00FF00, '0},
    '{EXP_PREDICT, 24'h0000FF, '0},
    '{EXP_PREDICT, 24'hFFFF00, '0},
    '{EXP_PREDICT, 24'h00FFFF, '0},
    '{EXP_PREDICT, 24'hFF00FF, '0},
    '{EXP_PREDICT, 24'h804020, '0},
    '{EXP_PREDICT, 24'h010203, '0},
    '{EXP_PREDICT, 24'hFEFD7F, '0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  pix_t              in_data;
  logic              out_valid;
  logic              out_stall;
  res_t              out_data;
  logic              cfg_wr_en;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  // model state
  logic [CFG_DW-1:0] width_reg;
  logic [CFG_DW-1:0] height_reg;
  logic [7:0]        thresh_reg;
  bit [7:0]          line_older [LINE_MAX];
  bit [7:0]          line_newer [LINE_MAX];
  int                win [6];
  int                pos_col;
  int                pos_row;

  res_t pending_judgments [$];
  res_t judged_want;
  int   err_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_armed;
  int   hold_count;
  int   cycle_count;

  sobel_edge_threshold #(
    .MAX_WIDTH (LINE_MAX),
    .MAX_HEIGHT(ROWS_MAX)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int size_in_use(input logic [CFG_DW-1:0] raw, input int top);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > top) return top;
    return int'(raw);
  endfunction

  function automatic void judge_pixel(input pix_t p, output bit has, output res_t res);
    int w, h, c, r, top, mid, bot, gx, gy, mag2, thr;
    w = size_in_use(width_reg, LINE_MAX);
    h = size_in_use(height_reg, ROWS_MAX);
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    c = pos_col;
    r = pos_row;
    top = line_older[c];
    mid = line_newer[c];
    bot = (LUMA_R * int'(p.red) + LUMA_G * int'(p.green) + LUMA_B * int'(p.blue)) >> 16;
    has = (r >= 2 && c >= 2);
    res = '0;
    if (has) begin
      gx = (win[0] + 2 * win[1] + win[2]) - (top + 2 * mid + bot);
      gy = (win[0] + 2 * win[3] + top) - (win[2] + 2 * win[5] + bot);
      mag2 = gx * gx + gy * gy;
      thr = thresh_reg;
      res.edge_res = (mag2 > 64 * thr * thr);
      res.out_column = 10'(c - 1);
      res.out_row = 10'(r - 1);
      res.last_of_frame = (c == w - 1 && r == h - 1);
    end
    line_older[c] = 8'(mid);
    line_newer[c] = 8'(bot);
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = bot;
    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= h) pos_row = 0;
    end
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 66;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct <= 66;
      end
      IDLE_BOTH: begin
        send_idle_pct = 17;
        recv_stall_pct <= 17;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = val;
      REG_IMAGE_HEIGHT: height_reg = val;
      default:          thresh_reg = val[7:0];
    endcase
  endtask

  // registers only change once the pipeline has drained
  task automatic set_frame(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                           input logic [CFG_DW-1:0] t);
    in_valid <= 1'b0;
    while (pending_judgments.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_EDGE_THRESHOLD, t);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic offer_pixel(input pix_t p, input exp_kind_e kind, input res_t given);
    bit   has;
    res_t judged;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data <= 24'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    judge_pixel(p, has, judged);
    if (kind == EXP_GIVEN) pending_judgments.push_back(given);
    else if (kind == EXP_PREDICT && has) pending_judgments.push_back(judged);
  endtask

  // repeat_pct sets how often a pixel copies the previous one (flat patches)
  task automatic run_pixels(input int count, input int repeat_pct);
    pix_t p;
    p = 24'($urandom);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) >= repeat_pct) p = 24'($urandom);
      offer_pixel(p, EXP_PREDICT, '0);
    end
  endtask

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // receiver: one long hold-off once armed, random stalls otherwise
  always @(posedge clk) begin
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_judgments.size() == 0) begin
        note_failure($sformatf("unexpected request: edge %0d col %0d row %0d last %0d",
                               out_data.edge_res, out_data.out_column, out_data.out_row,
                               out_data.last_of_frame));
      end else begin
        judged_want = pending_judgments.pop_front();
        if (out_data.edge_res !== judged_want.edge_res ||
            out_data.out_column !== judged_want.out_column ||
            out_data.out_row !== judged_want.out_row ||
            out_data.last_of_frame !== judged_want.last_of_frame)
          note_failure($sformatf(
            "mismatch: exp edge %0d col %0d row %0d last %0d, got %0d %0d %0d %0d",
            judged_want.edge_res, judged_want.out_column, judged_want.out_row,
            judged_want.last_of_frame, out_data.edge_res, out_data.out_column,
            out_data.out_row, out_data.last_of_frame));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int                ph;
    int                k;
    int                w_top;
    int                t;
    logic [CFG_DW-1:0] w_raw;
    logic [CFG_DW-1:0] h_raw;
    err_count = 0;
    hold_count = 0;
    cycle_count = 0;
    hold_armed = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    width_reg = IMAGE_WIDTH_RST;
    height_reg = IMAGE_HEIGHT_RST;
    thresh_reg = EDGE_THRESHOLD_RST;
    win = '{default: 0};
    pos_col = 0;
    pos_row = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // under-range sizes clamp to 3x3, zero threshold
    set_idling(IDLE_BOTH);
    set_frame(11'd0, 11'd1, 11'd0);
    foreach (DIRECTED_ROWS[i])
      offer_pixel(DIRECTED_ROWS[i].pix, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].res);

    // receiver held off past the first interior pixels so the input backs up
    set_idling(IDLE_NONE);
    set_frame(11'd40, 11'd2, 11'($urandom_range(0, 60)));
    hold_armed <= 1'b1;
    run_pixels(160, 80);

    // tallest frame, entered mid-frame, left mid-frame by the next height write
    set_idling(IDLE_BOTH);
    set_frame(11'd3, 11'd2047, 11'($urandom_range(0, 60)));
    run_pixels(200, 60);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      set_idling(idle_mode_e'(ph % 4));
      // width may only grow at a frame start, else unwritten line entries get used
      w_top = (pos_row == 0 && pos_col == 0) ? 12 : size_in_use(width_reg, LINE_MAX);
      if ($urandom_range(0, 7) == 0) w_raw = 11'($urandom_range(0, 2));
      else w_raw = 11'($urandom_range(MIN_SIZE, w_top));
      if ($urandom_range(0, 7) == 0) h_raw = 11'($urandom_range(0, 2));
      else h_raw = 11'($urandom_range(MIN_SIZE, 8));
      case (ph % 5)
        1:       t = 255;
        2:       t = 0;
        default: t = $urandom_range(0, 120);
      endcase
      set_frame(w_raw, h_raw, {3'($urandom), 8'(t)});
      run_pixels($urandom_range(20, 60), $urandom_range(0, 90));
    end

    in_valid <= 1'b0;
    for (k = 0; k < END_WAIT && pending_judgments.size() != 0; k++) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (pending_judgments.size() != 0) begin
      $display("%0d expected requests never arrived", pending_judgments.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
